/* rtl/mds_pkg.sv */
// Shared constants and types for the 2x2 mip downsampler.
package mds_pkg;

  localparam int NUM_CH     = 4;
  localparam int CH_W       = 8;
  localparam int PIX_W      = NUM_CH * CH_W;
  localparam int PAIR_CH_W  = CH_W + 1;
  localparam int PAIR_W     = NUM_CH * PAIR_CH_W;
  localparam int SUM_CH_W   = CH_W + 2;
  localparam int CFG_W      = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int HW         = $clog2(MAX_HEIGHT + 1);
  localparam int RW         = $clog2(MAX_HEIGHT);
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  // Register select, taken from the word address bit.
  localparam logic REG_SRC_WIDTH  = 1'b0;
  localparam logic REG_SRC_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic [PAIR_W-1:0] pair_t;

  // Control carried with an item from the input stage to the output stage.
  typedef struct packed {
    logic       use_mem;
    logic [1:0] shift;
    logic       last;
  } ctl_t;

endpackage

/* rtl/mip_downsample_2x2.sv */
// Streaming 2x2 box-filter downsampler for RGBA8 pixels in raster order.
// A pixel that closes a block is registered in s1, then in the output register, before out_tvalid.
// Throughput: 1 source pixel per cycle unless out_tready stalls; the line store has one write and one read port.
// Reset (rst_n, synchronous, active low): counters, held pixel and pipeline valids clear,
// src_width and src_height return to 1. The line store is not cleared: an entry is
// always written on an even row before the odd row below reads it.
module mip_downsample_2x2
  import mds_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  // input pixel stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [PIX_W-1:0]  in_tdata,     // in_red, in_green, in_blue, in_alpha
  // downsampled pixel stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [PIX_W-1:0]  out_tdata,    // out_red, out_green, out_blue, out_alpha
  output logic              out_tlast,    // frame_end
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int SW         = $clog2(MAX_WIDTH + 1);
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int XW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CMPW       = (SW > CFG_W) ? SW : CFG_W;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] cfg_width_r, cfg_height_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= CFG_W'(1);
      cfg_height_r <= CFG_W'(1);
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_SRC_WIDTH:  cfg_width_r  <= cfg_pwdata[CFG_W-1:0];
        REG_SRC_HEIGHT: cfg_height_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_SRC_WIDTH:  cfg_prdata = APB_DW'(cfg_width_r);
      REG_SRC_HEIGHT: cfg_prdata = APB_DW'(cfg_height_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // clamped image size
  logic [CMPW-1:0] w_ext, w_clamp;
  logic [SW-1:0]   w, nw;
  logic [HW-1:0]   h, nh;
  logic            wide, tall;

  always_comb begin
    w_ext = CMPW'(cfg_width_r);
    if (w_ext == '0)                    w_clamp = CMPW'(1);
    else if (w_ext > CMPW'(MAX_WIDTH))  w_clamp = CMPW'(MAX_WIDTH);
    else                                w_clamp = w_ext;
    w = SW'(w_clamp);
    if (cfg_height_r == '0)                     h = HW'(1);
    else if (cfg_height_r > CFG_W'(MAX_HEIGHT)) h = HW'(MAX_HEIGHT);
    else                                        h = HW'(cfg_height_r);
    wide = (w > SW'(1));
    tall = (h > HW'(1));
    nw   = wide ? (w >> 1) : SW'(1);
    nh   = tall ? (h >> 1) : HW'(1);
  end

  // ---------------- input stage ----------------
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  pixel_t        held_r;
  logic          in_xfer;

  logic          s1_valid_r;
  pair_t         s1_pair_r;
  ctl_t          s1_ctl_r;
  logic          s1_move;
  logic          out_valid_r;

  pixel_t        px;
  pair_t         pair;
  logic          col_ok, row_ok;
  logic [XW-1:0] x;
  logic [HW-1:0] y;
  logic          wr_en, emit;
  ctl_t          ctl;

  assign px      = in_tdata;
  assign s1_move = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_xfer = in_tvalid && in_tready;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      pair[i*PAIR_CH_W +: PAIR_CH_W] = PAIR_CH_W'(px[i*CH_W +: CH_W])
          + (wide ? PAIR_CH_W'(held_r[i*CH_W +: CH_W]) : PAIR_CH_W'(0));
    end
    col_ok = wide ? (col_r[0] && (SW'(col_r) < w)) : (col_r == '0);
    row_ok = HW'(row_r) < h;
    x      = wide ? XW'(col_r >> 1) : XW'(0);
    y      = tall ? HW'(row_r >> 1) : HW'(0);
    wr_en  = col_ok && tall && row_ok && !row_r[0];
    emit   = col_ok && (tall ? (row_ok && row_r[0]) : (row_r == '0));
    ctl.use_mem = tall;
    // divide by the number of pixels that went into the sum
    ctl.shift   = 2'(wide) + 2'(tall);
    ctl.last    = (SW'(x) == nw - SW'(1)) && (y == nh - HW'(1));
  end

  // position counters and held left pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else if (in_xfer) begin
      if (wide && !col_r[0]) held_r <= px;
      if (SW'(col_r) >= w - SW'(1)) begin
        col_r <= '0;
        row_r <= (HW'(row_r) >= h - HW'(1)) ? '0 : row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // line store of pair sums from even rows
  pair_t line_mem [LINE_DEPTH];
  pair_t line_rd_r;

  always_ff @(posedge clk) begin
    if (in_xfer && wr_en) line_mem[x] <= pair;
    if (in_xfer && emit)  line_rd_r   <= line_mem[x];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= emit;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      s1_pair_r <= pair;
      s1_ctl_r  <= ctl;
    end
  end

  // ---------------- output stage ----------------
  pixel_t              avg;
  logic [SUM_CH_W-1:0] sum_ch;
  logic [SUM_CH_W-1:0] avg_ch;
  pixel_t              out_data_r;
  logic                out_last_r;

  always_comb begin
    avg = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      sum_ch = SUM_CH_W'(s1_pair_r[i*PAIR_CH_W +: PAIR_CH_W])
          + (s1_ctl_r.use_mem ? SUM_CH_W'(line_rd_r[i*PAIR_CH_W +: PAIR_CH_W])
                              : SUM_CH_W'(0));
      avg_ch = sum_ch >> s1_ctl_r.shift;
      avg[i*CH_W +: CH_W] = avg_ch[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= avg;
      out_last_r <= s1_ctl_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
